// ----- rtl/pafifo_pkg.sv -----
// pafifo_pkg: shared types and constants of the primed audio playout FIFO.
// No dependencies; imported by pafifo_ctrl and primed_audio_playout_fifo_unit.
package pafifo_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 13;
	localparam int CNT_W    = 32;

	localparam logic [LEVEL_W-1:0] PRIME_RESET = LEVEL_W'(5760);

	typedef enum logic [1:0] {
		OP_PUSH    = 2'd0,
		OP_POP     = 2'd1,
		OP_FLUSH   = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef struct packed {
		logic               sample_valid;
		logic               underrun_now;
		logic               dropped_now;
		logic               is_primed;
		logic [LEVEL_W-1:0] fill_level;
		logic [CNT_W-1:0]   underrun_total;
		logic [CNT_W-1:0]   dropped_total;
	} res_t;

endpackage

// ----- rtl/pafifo_ram.sv -----
// pafifo_ram: sample store, one write port and one read port, registered read.
// No dependencies; instantiated by primed_audio_playout_fifo_unit.
module pafifo_ram #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/pafifo_ctrl.sv -----
// pafifo_ctrl: ring pointers, primed mark, counters and threshold register.
// Depends on pafifo_pkg; drives the sample store ports and the result beat.
module pafifo_ctrl #(
	parameter int DEPTH = 8192,
	parameter int PW    = 14,
	parameter int AW    = 13
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [pafifo_pkg::LEVEL_W-1:0]     cfg_wr_data,
	input  logic                               accept,
	input  logic [1:0]                         op,
	output logic                               mem_wr_en,
	output logic [AW-1:0]                      mem_wr_addr,
	output logic                               mem_rd_en,
	output logic [AW-1:0]                      mem_rd_addr,
	output pafifo_pkg::res_t                   res
);
	import pafifo_pkg::*;

	localparam int XW = (PW > LEVEL_W) ? PW : LEVEL_W;
	localparam logic [PW:0]   TWO_D    = (PW+1)'(2 * DEPTH);
	localparam logic [PW-1:0] PTR_LAST = PW'(2 * DEPTH - 1);
	localparam logic [PW-1:0] D_PTR    = PW'(DEPTH);
	localparam logic [PW-1:0] FULL_LVL = PW'(DEPTH - 1);

	logic [PW-1:0]      rd_ptr_q, wr_ptr_q;
	logic               primed_q;
	logic [CNT_W-1:0]   und_cnt_q, drp_cnt_q;
	logic [LEVEL_W-1:0] thr_q;

	logic [PW:0]        fill_wide;
	logic [PW-1:0]      fill, fill_nxt;
	logic [XW-1:0]      fill_x, thr_x;
	logic               full, empty, primed_eff;
	logic               do_push, do_read, do_drop, do_und;
	logic [PW-1:0]      rd_ptr_nxt, wr_ptr_nxt;
	logic               primed_nxt;
	logic [CNT_W-1:0]   und_cnt_nxt, drp_cnt_nxt;
	op_t                op_c;

	function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_slot(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		s = (p >= D_PTR) ? p - D_PTR : p;
		return s[AW-1:0];
	endfunction

	assign op_c = op_t'(op);

	always_comb begin
		fill_wide = {1'b0, wr_ptr_q} - {1'b0, rd_ptr_q};
		if (wr_ptr_q < rd_ptr_q) begin
			fill_wide = fill_wide + TWO_D;
		end
		fill  = fill_wide[PW-1:0];
		full  = (fill >= FULL_LVL);
		empty = (fill == '0);
		thr_x = XW'(thr_q);
		fill_x = XW'(fill);
		primed_eff = primed_q | (fill_x >= thr_x);
	end

	always_comb begin
		do_push     = 1'b0;
		do_drop     = 1'b0;
		do_read     = 1'b0;
		do_und      = 1'b0;
		rd_ptr_nxt  = rd_ptr_q;
		wr_ptr_nxt  = wr_ptr_q;
		primed_nxt  = primed_q;
		und_cnt_nxt = und_cnt_q;
		drp_cnt_nxt = drp_cnt_q;
		fill_nxt    = fill;
		unique case (op_c)
			OP_PUSH: begin
				if (full) begin
					do_drop     = 1'b1;
					drp_cnt_nxt = drp_cnt_q + CNT_W'(1);
				end else begin
					do_push    = 1'b1;
					wr_ptr_nxt = ptr_inc(wr_ptr_q);
					fill_nxt   = fill + PW'(1);
				end
			end
			OP_POP: begin
				primed_nxt = primed_eff;
				if (primed_eff) begin
					if (empty) begin
						do_und      = 1'b1;
						primed_nxt  = 1'b0;
						und_cnt_nxt = und_cnt_q + CNT_W'(1);
					end else begin
						do_read    = 1'b1;
						rd_ptr_nxt = ptr_inc(rd_ptr_q);
						fill_nxt   = fill - PW'(1);
					end
				end
			end
			OP_FLUSH: begin
				rd_ptr_nxt = wr_ptr_q;
				primed_nxt = 1'b0;
				fill_nxt   = '0;
			end
			OP_RESTART: begin
				rd_ptr_nxt  = '0;
				wr_ptr_nxt  = '0;
				primed_nxt  = 1'b0;
				und_cnt_nxt = '0;
				drp_cnt_nxt = '0;
				fill_nxt    = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q  <= '0;
			wr_ptr_q  <= '0;
			primed_q  <= 1'b0;
			und_cnt_q <= '0;
			drp_cnt_q <= '0;
		end else if (accept) begin
			rd_ptr_q  <= rd_ptr_nxt;
			wr_ptr_q  <= wr_ptr_nxt;
			primed_q  <= primed_nxt;
			und_cnt_q <= und_cnt_nxt;
			drp_cnt_q <= drp_cnt_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= PRIME_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	logic [XW-1:0] fill_nxt_x;

	always_comb begin
		fill_nxt_x         = XW'(fill_nxt);
		res.sample_valid   = do_read;
		res.underrun_now   = do_und;
		res.dropped_now    = do_drop;
		res.is_primed      = primed_nxt;
		res.fill_level     = fill_nxt_x[LEVEL_W-1:0];
		res.underrun_total = und_cnt_nxt;
		res.dropped_total  = drp_cnt_nxt;
	end

	assign mem_wr_en   = accept & do_push;
	assign mem_wr_addr = ptr_slot(wr_ptr_q);
	assign mem_rd_en   = accept & do_read;
	assign mem_rd_addr = ptr_slot(rd_ptr_q);

endmodule

// ----- rtl/primed_audio_playout_fifo_unit.sv -----
// primed_audio_playout_fifo_unit: top level of the primed playout ring FIFO.
// Depends on pafifo_pkg, pafifo_ram and pafifo_ctrl.
//
// channel   direction  handshake           payload
// input     in         in_valid/in_stall   op, sample_in
// result    out        out_valid/out_stall sample_out, sample_valid, underrun_now,
//                                          dropped_now, is_primed, fill_level,
//                                          underrun_total, dropped_total
// config    in         cfg_wr_en           cfg_wr_data (prime threshold)
//
// One beat per cycle unless stalled; a result appears the cycle after its beat,
// popped data comes straight from the store's registered read port.
// in_stall rises only while a result is held and out_stall is high.
// arst_n clears pointers, primed mark and counters, sets the threshold to 5760;
// store contents are not cleared and no entry is read before it is written.
module primed_audio_playout_fifo_unit #(
	parameter int DEPTH = 8192
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [pafifo_pkg::LEVEL_W-1:0]     cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         op,
	input  logic signed [pafifo_pkg::SAMPLE_W-1:0] sample_in,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pafifo_pkg::SAMPLE_W-1:0] sample_out,
	output logic                               sample_valid,
	output logic                               underrun_now,
	output logic                               dropped_now,
	output logic                               is_primed,
	output logic [pafifo_pkg::LEVEL_W-1:0]     fill_level,
	output logic [pafifo_pkg::CNT_W-1:0]       underrun_total,
	output logic [pafifo_pkg::CNT_W-1:0]       dropped_total
);
	import pafifo_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(2 * DEPTH);

	logic                accept;
	logic                mem_wr_en, mem_rd_en;
	logic [AW-1:0]       mem_wr_addr, mem_rd_addr;
	logic [SAMPLE_W-1:0] rd_data;
	res_t                res;
	res_t                res_s1;
	logic                valid_s1;

	assign in_stall = valid_s1 & out_stall;
	assign accept   = in_valid & ~in_stall;

	pafifo_ctrl #(
		.DEPTH (DEPTH),
		.PW    (PW),
		.AW    (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.accept      (accept),
		.op          (op),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.res         (res)
	);

	pafifo_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (SAMPLE_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (sample_in),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1 <= res;
		end
	end

	assign out_valid      = valid_s1;
	assign sample_out     = res_s1.sample_valid ? rd_data : '0;
	assign sample_valid   = res_s1.sample_valid;
	assign underrun_now   = res_s1.underrun_now;
	assign dropped_now    = res_s1.dropped_now;
	assign is_primed      = res_s1.is_primed;
	assign fill_level     = res_s1.fill_level;
	assign underrun_total = res_s1.underrun_total;
	assign dropped_total  = res_s1.dropped_total;

endmodule
